@@ sv/afs_pkg.sv @@
// ----------------------------------------------------------------------------
// afs_pkg
// shared constants, command and result types for the animation frame selector
// ----------------------------------------------------------------------------
package afs_pkg;

	localparam int MAX_FRAMES = 64;
	localparam int IDX_W      = $clog2(MAX_FRAMES);
	localparam int CNT_W      = $clog2(MAX_FRAMES + 1);
	localparam int DUR_W      = 16;
	localparam int TIME_W     = DUR_W + IDX_W;
	localparam int SAMPLE_W   = 32;
	localparam int CLAMP_W    = SAMPLE_W - 1;
	localparam int KIND_W     = 2;
	localparam int FRAME_W    = 6;
	localparam int STATUS_W   = 2;
	localparam int STEP_W     = $clog2(CLAMP_W);

	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_APPEND = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

	typedef enum logic [1:0] {
		OP_NOP,
		OP_CLEAR,
		OP_APPEND,
		OP_SAMPLE
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK     = 2'd0,
		ST_REJECT = 2'd1,
		ST_EMPTY  = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MOD,
		BK_RD,
		BK_CMP,
		BK_DONE
	} bk_state_t;

	typedef struct packed {
		op_t                op;
		logic [DUR_W-1:0]   dur;
		logic [CLAMP_W-1:0] t;
	} cmd_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame;
		status_t            status;
	} res_t;

endpackage

@@ sv/afs_front.sv @@
// ----------------------------------------------------------------------------
// afs_front
// accepts input items, decodes kind and clamps time, queues commands
// ----------------------------------------------------------------------------
module afs_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic [afs_pkg::KIND_W-1:0]       kind,
	input  logic [afs_pkg::DUR_W-1:0]        frame_duration,
	input  logic signed [afs_pkg::SAMPLE_W-1:0] clip_time,
	output logic                             cmd_valid,
	input  logic                             cmd_ready,
	output afs_pkg::cmd_t                    cmd
);
	import afs_pkg::*;

	cmd_t       queue_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       in_cmd;
	logic       push;
	logic       pop;

	// decode
	always_comb begin
		in_cmd.dur = frame_duration;
		in_cmd.t   = clip_time[SAMPLE_W-1] ? '0 : clip_time[CLAMP_W-1:0];
		case (kind)
			KIND_CLEAR:  in_cmd.op = OP_CLEAR;
			KIND_APPEND: in_cmd.op = OP_APPEND;
			KIND_SAMPLE: in_cmd.op = OP_SAMPLE;
			default:     in_cmd.op = OP_NOP;
		endcase
	end

	assign in_ready  = (count_q != 2'd2);
	assign cmd_valid = (count_q != 2'd0);
	assign cmd       = queue_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = cmd_valid && cmd_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= in_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ sv/afs_mod.sv @@
// ----------------------------------------------------------------------------
// afs_mod
// bit-serial restoring remainder, one dividend bit per cycle
// ----------------------------------------------------------------------------
module afs_mod (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [afs_pkg::CLAMP_W-1:0]  dividend,
	input  logic [afs_pkg::TIME_W-1:0]   divisor,
	output logic                         done,
	output logic [afs_pkg::TIME_W-1:0]   rem
);
	import afs_pkg::*;

	logic                busy_q;
	logic                done_q;
	logic [STEP_W-1:0]   cnt_q;
	logic [CLAMP_W-1:0]  dvd_q;
	logic [TIME_W-1:0]   rem_q;
	logic [TIME_W:0]     shifted;
	logic [TIME_W:0]     diff;
	logic                fits;

	assign shifted = {rem_q, dvd_q[CLAMP_W-1]};
	assign fits    = (shifted >= {1'b0, divisor});
	assign diff    = shifted - {1'b0, divisor};
	assign done    = done_q;
	assign rem     = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(CLAMP_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[CLAMP_W-2:0], 1'b0};
			rem_q <= fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
		end
	end

endmodule

@@ sv/afs_back.sv @@
// ----------------------------------------------------------------------------
// afs_back
// executes commands: end time table, clip length, wrap and binary search
// ----------------------------------------------------------------------------
module afs_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           loop_mode,
	input  logic           cmd_valid,
	output logic           cmd_ready,
	input  afs_pkg::cmd_t  cmd,
	output logic           res_valid,
	input  logic           res_ready,
	output afs_pkg::res_t  res
);
	import afs_pkg::*;

	bk_state_t          state_q;
	bk_state_t          state_d;
	logic [CNT_W-1:0]   total_q;
	logic [TIME_W-1:0]  clip_q;
	logic [CLAMP_W-1:0] t_q;
	logic [CNT_W-1:0]   lo_q;
	logic [CNT_W-1:0]   hi_q;
	logic [CNT_W-1:0]   mid_q;
	logic [TIME_W-1:0]  rd_data_q;
	res_t               res_q;
	logic [TIME_W-1:0]  mem [MAX_FRAMES];

	logic               take;
	logic               mod_start;
	logic               mod_done;
	logic [TIME_W-1:0]  mod_rem;
	logic               is_empty;
	logic               app_reject;
	logic               past_end;
	logic [TIME_W-1:0]  new_clip;
	logic [CNT_W-1:0]   mid;
	logic               later;
	logic [CNT_W-1:0]   lo_n;
	logic [CNT_W-1:0]   hi_n;
	logic [CNT_W-1:0]   found;
	logic [CNT_W-1:0]   last;

	afs_mod u_mod (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (mod_start),
		.dividend (cmd.t),
		.divisor  (clip_q),
		.done     (mod_done),
		.rem      (mod_rem)
	);

	assign take       = cmd_valid && (state_q == BK_IDLE);
	assign is_empty   = (total_q == '0) || (clip_q == '0);
	assign app_reject = (cmd.dur == '0) || (total_q >= CNT_W'(MAX_FRAMES));
	assign past_end   = ({{(CLAMP_W-TIME_W){1'b0}}, clip_q} <= cmd.t);
	assign new_clip   = clip_q + {{(TIME_W-DUR_W){1'b0}}, cmd.dur};
	assign mid        = lo_q + ((hi_q - lo_q) >> 1);
	assign later      = ({{(CLAMP_W-TIME_W){1'b0}}, rd_data_q} > t_q);
	assign lo_n       = later ? lo_q : mid_q + CNT_W'(1);
	assign hi_n       = later ? mid_q : hi_q;
	assign last       = total_q - CNT_W'(1);
	assign found      = (lo_n >= total_q) ? (loop_mode ? '0 : last) : lo_n;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (take) begin
					if (cmd.op == OP_SAMPLE && !is_empty) begin
						if (loop_mode) begin
							state_d = BK_MOD;
						end else if (past_end) begin
							state_d = BK_DONE;
						end else begin
							state_d = BK_RD;
						end
					end else begin
						state_d = BK_DONE;
					end
				end
			end
			BK_MOD: begin
				if (mod_done) begin
					state_d = BK_RD;
				end
			end
			BK_RD:  state_d = BK_CMP;
			BK_CMP: state_d = (lo_n < hi_n) ? BK_RD : BK_DONE;
			BK_DONE: begin
				if (res_ready) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd_ready = 1'b0;
		res_valid = 1'b0;
		mod_start = 1'b0;
		case (state_q)
			BK_IDLE: begin
				cmd_ready = 1'b1;
				mod_start = cmd_valid && (cmd.op == OP_SAMPLE) && !is_empty && loop_mode;
			end
			BK_DONE: res_valid = 1'b1;
			default: ;
		endcase
	end

	assign res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
			total_q <= '0;
			clip_q  <= '0;
		end else begin
			state_q <= state_d;
			if (take) begin
				case (cmd.op)
					OP_CLEAR: begin
						total_q <= '0;
						clip_q  <= '0;
					end
					OP_APPEND: begin
						if (!app_reject) begin
							total_q <= total_q + CNT_W'(1);
							clip_q  <= new_clip;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// search and result datapath
	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				t_q        <= cmd.t;
				lo_q       <= '0;
				hi_q       <= total_q;
				res_q.frame  <= '0;
				res_q.status <= ST_OK;
				if (cmd.op == OP_APPEND && app_reject) begin
					res_q.status <= ST_REJECT;
				end
				if (cmd.op == OP_SAMPLE) begin
					if (is_empty) begin
						res_q.status <= ST_EMPTY;
					end else if (past_end) begin
						res_q.frame <= FRAME_W'(last);
					end
				end
			end
			BK_MOD: begin
				if (mod_done) begin
					t_q <= {{(CLAMP_W-TIME_W){1'b0}}, mod_rem};
				end
			end
			BK_RD: mid_q <= mid;
			BK_CMP: begin
				lo_q        <= lo_n;
				hi_q        <= hi_n;
				res_q.frame <= FRAME_W'(found);
			end
			default: ;
		endcase
	end

	// end time table
	always_ff @(posedge clk) begin
		if (take && cmd.op == OP_APPEND && !app_reject) begin
			mem[total_q[IDX_W-1:0]] <= new_clip;
		end
		if (state_q == BK_RD) begin
			rd_data_q <= mem[mid[IDX_W-1:0]];
		end
	end

endmodule

@@ sv/animation_frame_selector_top.sv @@
// ----------------------------------------------------------------------------
// animation_frame_selector_top
// frame lookup on a timeline of cumulative frame end times
// ----------------------------------------------------------------------------
// Each input item is a clear, an append of a frame duration, or a sample of a
// clip time, and each gives exactly one result (frame_index, status). Items go
// into a two-deep command queue and are executed one at a time by the back
// end, which owns the end time table (a 64-entry memory with registered read),
// the frame count and the clip length; the output register lets the next item
// start while a result still waits. A sample within the clip runs a binary
// search over the table in which each step passes through a read state and a
// compare state, since the memory read is registered; in loop mode the
// bit-serial remainder unit first wraps the time. loop_mode is register 0 at
// byte addresses 0 to 3 on the APB port and resets to 1.
// ----------------------------------------------------------------------------
module animation_frame_selector_top (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [2:0]                        paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	// input items
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [afs_pkg::KIND_W-1:0]        kind,
	input  logic [afs_pkg::DUR_W-1:0]         frame_duration,
	input  logic signed [afs_pkg::SAMPLE_W-1:0] clip_time,
	// results
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [afs_pkg::FRAME_W-1:0]       frame_index,
	output logic [afs_pkg::STATUS_W-1:0]      status
);
	import afs_pkg::*;

	logic  loop_mode_q;
	logic  cmd_valid;
	logic  cmd_ready;
	cmd_t  cmd;
	logic  res_valid;
	logic  res_ready;
	res_t  res;
	logic  out_valid_q;
	res_t  out_q;

	// register 0 sits at byte addresses 0 to 3, addresses 4 to 7 read as zero
	assign pready = 1'b1;
	assign prdata = (paddr[2] == 1'b0) ? {31'b0, loop_mode_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_mode_q <= 1'b1;
		end else if (psel && penable && pwrite && pready && paddr[2] == 1'b0) begin
			loop_mode_q <= pwdata[0];
		end
	end

	// front: decode and queue
	afs_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.frame_duration (frame_duration),
		.clip_time      (clip_time),
		.cmd_valid      (cmd_valid),
		.cmd_ready      (cmd_ready),
		.cmd            (cmd)
	);

	// back: table, wrap and search
	afs_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.loop_mode (loop_mode_q),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// output register, refilled in the same cycle its transfer completes
	assign res_ready = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid   = out_valid_q;
	assign frame_index = out_q.frame;
	assign status      = out_q.status;

endmodule
